// File: rtl/pfd_pkg.sv
package pfd_pkg;

   // key square geometry
   localparam int SqDim   = 5;
   localparam int CharW   = 8;
   localparam int RowW    = SqDim * CharW;
   localparam int PosW    = 3;
   localparam int CsrIdxW = 3;

   typedef logic [CharW-1:0]            char_type;
   typedef logic [PosW-1:0]             pos_type;
   typedef logic [SqDim-1:0][RowW-1:0]  square_type;

   // where a character sits in the square
   typedef struct packed {
      logic    found;
      pos_type row;
      pos_type col;
   } loc_type;

   // character at row r, column c
   function automatic char_type cell_at(square_type sq, pos_type r, pos_type c);
      return sq[r][c*CharW +: CharW];
   endfunction

   // previous index with wrap from 0 to the last row or column
   function automatic pos_type prev_pos(pos_type p);
      return (p == '0) ? pos_type'(SqDim - 1) : pos_type'(p - pos_type'(1));
   endfunction

   // first match in row-major order; all compares are independent
   function automatic loc_type locate(square_type sq, char_type ch);
      loc_type res;
      res = '0;
      for (int r = SqDim - 1; r >= 0; r--) begin
         for (int c = SqDim - 1; c >= 0; c--) begin
            if (sq[r][c*CharW +: CharW] == ch) begin
               res.found = 1'b1;
               res.row   = pos_type'(r);
               res.col   = pos_type'(c);
            end
         end
      end
      return res;
   endfunction

endpackage

// File: rtl/playfair_digraph_decrypt_top.sv
// path: an accepted req item goes through the input and result registers to rsp_tvalid
// throughput: one digraph per cycle unless rsp_tready stalls; input register and
// result register are separate, so an empty input stage fills while a result waits
// reset: synchronous, clears both valid flags and the five key square rows
module playfair_digraph_decrypt_top (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [2*pfd_pkg::CharW-1:0]      req_tdata,  // cipher_first, cipher_second
   input  logic                             req_tlast,  // last_pair
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [2*pfd_pkg::CharW-1:0]      rsp_tdata,  // plain_first, plain_second
   output logic                             rsp_tuser,  // not_in_square
   output logic                             rsp_tlast,  // last_pair_out
   // configuration
   input  logic                             csr_wr_en,
   input  logic [pfd_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [pfd_pkg::RowW-1:0]         csr_wr_data
);
   import pfd_pkg::*;

   square_type square_ff, square_in;

   logic     in_valid_ff, in_valid_in;
   char_type in_first_ff, in_first_in;
   char_type in_second_ff, in_second_in;
   logic     in_last_ff, in_last_in;

   logic     out_valid_ff, out_valid_in;
   char_type out_first_ff, out_first_in;
   char_type out_second_ff, out_second_in;
   logic     out_miss_ff, out_miss_in;
   logic     out_last_ff, out_last_in;

   logic     out_ready;
   logic     in_ready;
   loc_type  loc_a, loc_b;
   char_type p1, p2;
   logic     miss;

   // key square row writes, indexes past the last row are dropped
   always_comb begin
      square_in = square_ff;
      if (csr_wr_en && (csr_index < CsrIdxW'(SqDim))) begin
         square_in[csr_index] = csr_wr_data;
      end
   end

   // pipeline handshake
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign in_ready   = !in_valid_ff || out_ready;
   assign req_tready = in_ready;

   // input register
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_first_in  = in_first_ff;
      in_second_in = in_second_ff;
      in_last_in   = in_last_ff;
      if (in_ready) begin
         in_valid_in  = req_tvalid;
         in_first_in  = req_tdata[CharW-1:0];
         in_second_in = req_tdata[2*CharW-1:CharW];
         in_last_in   = req_tlast;
      end
   end

   // locate both characters and pick the plaintext pair
   always_comb begin
      loc_a = locate(square_ff, in_first_ff);
      loc_b = locate(square_ff, in_second_ff);
      miss  = !(loc_a.found && loc_b.found);
      if (miss) begin
         p1 = in_first_ff;
         p2 = in_second_ff;
      end else if (loc_a.row == loc_b.row) begin
         p1 = cell_at(square_ff, loc_a.row, prev_pos(loc_a.col));
         p2 = cell_at(square_ff, loc_b.row, prev_pos(loc_b.col));
      end else if (loc_a.col == loc_b.col) begin
         p1 = cell_at(square_ff, prev_pos(loc_a.row), loc_a.col);
         p2 = cell_at(square_ff, prev_pos(loc_b.row), loc_b.col);
      end else begin
         p1 = cell_at(square_ff, loc_a.row, loc_b.col);
         p2 = cell_at(square_ff, loc_b.row, loc_a.col);
      end
   end

   // result register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      out_miss_in   = out_miss_ff;
      out_last_in   = out_last_ff;
      if (out_ready) begin
         out_valid_in  = in_valid_ff;
         out_first_in  = p1;
         out_second_in = p2;
         out_miss_in   = miss;
         out_last_in   = in_last_ff;
      end
   end

   // control state and key square
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         square_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         square_ff    <= square_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      in_first_ff   <= in_first_in;
      in_second_ff  <= in_second_in;
      in_last_ff    <= in_last_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_miss_ff   <= out_miss_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_second_ff, out_first_ff};
   assign rsp_tuser  = out_miss_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: rtl/pfd_checker.sv
module pfd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [2*pfd_pkg::CharW-1:0]  rsp_tdata,
   input logic                         rsp_tuser,
   input logic                         rsp_tlast
);
   import pfd_pkg::*;

   // a result never appears out of reset
   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set after reset");

   // a fresh result comes from an accepted item that passed through the input register
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && !reset, 2))
      else $error("result without matching input item");

   // a draining output always frees the input side
   a_ready_follows : assert property (@(posedge clock) disable iff (reset)
      (rsp_tready || !rsp_tvalid) |-> req_tready)
      else $error("input stalled while output can move");

   // stalled result holds its payload
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind playfair_digraph_decrypt_top pfd_checker u_pfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: bench/pfd_checker.sv
`timescale 1ns / 1ps

module pfd_scoreboard (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [2*pfd_pkg::CharW-1:0]   req_tdata,
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [2*pfd_pkg::CharW-1:0]   rsp_tdata,
   input  logic                          rsp_tuser,
   input  logic                          rsp_tlast,
   input  logic                          csr_wr_en,
   input  logic [pfd_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [pfd_pkg::RowW-1:0]      csr_wr_data,
   output int unsigned                   mismatch_count,
   output int unsigned                   outstanding
);

   typedef logic [pfd_pkg::CharW-1:0] letter_type;

   typedef struct packed {
      letter_type first;
      letter_type second;
      logic       absent;
      logic       last;
   } plain_digraph_type;

   // shadow copy of the key square
   pfd_pkg::square_type key_rows;
   plain_digraph_type   expected_plain[$];

   initial mismatch_count = 0;

   function automatic letter_type square_char(input int row, input int col);
      return key_rows[row][col*pfd_pkg::CharW +: pfd_pkg::CharW];
   endfunction

   // first hit scanning rows top to bottom, columns left to right
   function automatic bit find_letter(input letter_type ch, output int row, output int col);
      bit hit;
      hit = 1'b0;
      row = 0;
      col = 0;
      for (int r = 0; r < pfd_pkg::SqDim; r++) begin
         for (int c = 0; c < pfd_pkg::SqDim; c++) begin
            if (!hit && square_char(r, c) == ch) begin
               hit = 1'b1;
               row = r;
               col = c;
            end
         end
      end
      return hit;
   endfunction

   // playfair decryption of one digraph against the shadow square
   function automatic plain_digraph_type decipher_digraph(input letter_type a,
                                                          input letter_type b,
                                                          input logic last);
      plain_digraph_type res;
      int  r1, c1, r2, c2;
      bit  hit1, hit2;
      hit1 = find_letter(a, r1, c1);
      hit2 = find_letter(b, r2, c2);
      res.last   = last;
      res.absent = 1'b0;
      if (!hit1 || !hit2) begin
         res.first  = a;
         res.second = b;
         res.absent = 1'b1;
      end else if (r1 == r2) begin
         res.first  = square_char(r1, (c1 + pfd_pkg::SqDim - 1) % pfd_pkg::SqDim);
         res.second = square_char(r2, (c2 + pfd_pkg::SqDim - 1) % pfd_pkg::SqDim);
      end else if (c1 == c2) begin
         res.first  = square_char((r1 + pfd_pkg::SqDim - 1) % pfd_pkg::SqDim, c1);
         res.second = square_char((r2 + pfd_pkg::SqDim - 1) % pfd_pkg::SqDim, c2);
      end else begin
         res.first  = square_char(r1, c2);
         res.second = square_char(r2, c1);
      end
      return res;
   endfunction

   // compare results, predict new items, then track register writes
   always @(posedge clock) begin
      plain_digraph_type want;
      if (reset) begin
         key_rows = '0;
         expected_plain.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_plain.size() == 0) begin
               $error("unexpected result item: data %h user %b last %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_plain.pop_front();
               if (rsp_tdata[pfd_pkg::CharW-1:0] !== want.first) begin
                  $error("plain_first: expected %h, got %h",
                         want.first, rsp_tdata[pfd_pkg::CharW-1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[2*pfd_pkg::CharW-1:pfd_pkg::CharW] !== want.second) begin
                  $error("plain_second: expected %h, got %h",
                         want.second, rsp_tdata[2*pfd_pkg::CharW-1:pfd_pkg::CharW]);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.absent) begin
                  $error("not_in_square: expected %b, got %b", want.absent, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_pair_out: expected %b, got %b", want.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_plain.push_back(decipher_digraph(req_tdata[pfd_pkg::CharW-1:0],
                                     req_tdata[2*pfd_pkg::CharW-1:pfd_pkg::CharW],
                                     req_tlast));
         end
         // indexes past the last row are ignored
         if (csr_wr_en && csr_index < pfd_pkg::SqDim) begin
            key_rows[csr_index] = csr_wr_data;
         end
      end
      outstanding <= expected_plain.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   typedef logic [pfd_pkg::CharW-1:0] letter_type;

   localparam int RegRow0     = 0;
   localparam int RegCount    = 2 ** pfd_pkg::CsrIdxW;
   localparam int SegItems    = 300;
   localparam int SegCount    = 6;
   localparam int QuietSeg    = 3;
   localparam int IdlePercent = 13;
   localparam int DrainCycles = 6;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_tvalid  = 1'b0;
   logic                          req_tready;
   logic [2*pfd_pkg::CharW-1:0]   req_tdata   = '0;
   logic                          req_tlast   = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready  = 1'b0;
   logic [2*pfd_pkg::CharW-1:0]   rsp_tdata;
   logic                          rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_wr_en   = 1'b0;
   logic [pfd_pkg::CsrIdxW-1:0]   csr_index   = '0;
   logic [pfd_pkg::RowW-1:0]      csr_wr_data = '0;

   int unsigned         mismatch_count;
   int unsigned         outstanding;
   bit                  quiet = 1'b0;
   pfd_pkg::square_type cur_square = '0;

   always #1 clock = ~clock;

   playfair_digraph_decrypt_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   pfd_scoreboard u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= IdlePercent);
   end

   // drive one register write; the caller lowers the enable
   task automatic write_reg(input int idx, input logic [pfd_pkg::RowW-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx[pfd_pkg::CsrIdxW-1:0];
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic load_square(input pfd_pkg::square_type sq);
      for (int r = 0; r < pfd_pkg::SqDim; r++) begin
         write_reg(RegRow0 + r, sq[r]);
      end
      csr_wr_en  <= 1'b0;
      cur_square = sq;
   endtask

   function automatic pfd_pkg::square_type square_from_text(input string s);
      pfd_pkg::square_type sq;
      for (int i = 0; i < pfd_pkg::SqDim * pfd_pkg::SqDim; i++) begin
         sq[i / pfd_pkg::SqDim][(i % pfd_pkg::SqDim)*pfd_pkg::CharW +: pfd_pkg::CharW] = s[i];
      end
      return sq;
   endfunction

   // 25 different random letters
   function automatic pfd_pkg::square_type distinct_square();
      pfd_pkg::square_type sq;
      bit [255:0] taken;
      int v;
      taken = '0;
      for (int i = 0; i < pfd_pkg::SqDim * pfd_pkg::SqDim; i++) begin
         do v = $urandom_range(255); while (taken[v]);
         taken[v] = 1'b1;
         sq[i / pfd_pkg::SqDim][(i % pfd_pkg::SqDim)*pfd_pkg::CharW +: pfd_pkg::CharW] =
            letter_type'(v);
      end
      return sq;
   endfunction

   // letters from a small alphabet, so repeats are frequent
   function automatic pfd_pkg::square_type repeat_square();
      pfd_pkg::square_type sq;
      for (int i = 0; i < pfd_pkg::SqDim * pfd_pkg::SqDim; i++) begin
         sq[i / pfd_pkg::SqDim][(i % pfd_pkg::SqDim)*pfd_pkg::CharW +: pfd_pkg::CharW] =
            letter_type'($urandom_range(31));
      end
      return sq;
   endfunction

   function automatic letter_type pick_letter();
      int r, c;
      r = $urandom_range(pfd_pkg::SqDim - 1);
      c = $urandom_range(pfd_pkg::SqDim - 1);
      return cur_square[r][c*pfd_pkg::CharW +: pfd_pkg::CharW];
   endfunction

   // offer one digraph, with random gaps, and wait until it is taken
   task automatic send_digraph(input letter_type a, input letter_type b, input logic last);
      while (!quiet && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and wait for every result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // random digraph, mostly letters of the current square
   task automatic send_random_digraph();
      letter_type a, b;
      int k;
      k = $urandom_range(99);
      a = pick_letter();
      b = pick_letter();
      if (k >= 70 && k < 80) begin
         b = a;
      end else if (k >= 80 && k < 90) begin
         if ($urandom_range(1)) a = letter_type'($urandom_range(255));
         else b = letter_type'($urandom_range(255));
      end else if (k >= 90) begin
         a = letter_type'($urandom_range(255));
         b = letter_type'($urandom_range(255));
      end
      send_digraph(a, b, $urandom_range(7) == 0);
   endtask

   // stimulus
   initial begin
      pfd_pkg::square_type classic, edge_sq;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // square still all zero after reset
      send_digraph(8'h00, 8'h00, 1'b0);
      send_digraph(8'h41, 8'h00, 1'b1);
      drain();

      // textbook square: row, column, rectangle, doubled and absent letters
      classic = square_from_text("PLAYFIREXMBCDGHKNOQSTUVWZ");
      load_square(classic);
      send_digraph("L", "F", 1'b0);
      send_digraph("P", "A", 1'b0);
      send_digraph("R", "U", 1'b0);
      send_digraph("A", "V", 1'b0);
      send_digraph("P", "Z", 1'b0);
      send_digraph("H", "I", 1'b0);
      send_digraph("E", "E", 1'b0);
      send_digraph("P", "P", 1'b0);
      send_digraph("J", "A", 1'b0);
      send_digraph("A", "J", 1'b0);
      send_digraph(8'h00, 8'hFF, 1'b0);
      send_digraph(8'hFF, "Z", 1'b1);
      drain();

      // writes past the last row must leave the square alone
      for (int i = pfd_pkg::SqDim; i < RegCount; i++) begin
         write_reg(i, {pfd_pkg::RowW{1'b1}});
      end
      csr_wr_en <= 1'b0;
      send_digraph("Z", "T", 1'b0);
      send_digraph(8'hFF, 8'hFF, 1'b1);
      drain();

      // extreme row values with repeated letters
      edge_sq    = distinct_square();
      edge_sq[0] = {pfd_pkg::RowW{1'b1}};
      edge_sq[1] = '0;
      edge_sq[3] = {pfd_pkg::SqDim{8'hFF}} ^ {{(pfd_pkg::SqDim / 2){16'h00FF}}, 8'h00};
      load_square(edge_sq);
      send_digraph(8'hFF, 8'h00, 1'b0);
      send_digraph(8'h00, 8'hFF, 1'b1);
      send_digraph(8'hFF, 8'hFF, 1'b0);
      send_digraph(8'h00, pick_letter(), 1'b0);
      send_digraph(pick_letter(), pick_letter(), 1'b1);
      drain();

      // random segments, each loading a square; the first reuses the textbook one
      for (int s = 0; s < SegCount; s++) begin
         if (s == 0) load_square(classic);
         else if (s % 2 == 1) load_square(distinct_square());
         else load_square(repeat_square());
         quiet = (s == QuietSeg);
         for (int i = 0; i < SegItems; i++) begin
            send_random_digraph();
         end
         drain();
      end
      quiet = 1'b0;

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
